[rtl/lhr_pkg.sv]
// Shared types and constants of the layer heating rate block.
// No dependencies; the divider, the top level and the checker import this package.

package lhr_pkg;

  localparam int FLUX_W     = 24;               // boundary flux, 1/256 W/m^2
  localparam int PRES_W     = 21;               // boundary pressure, 1/16 Pa
  localparam int SCALE_W    = 32;               // rate scale, unsigned Q16.16
  localparam int RATE_W     = 32;               // heating rate, 1/65536 K/day
  localparam int NET_W      = FLUX_W + 1;       // signed net flux at one boundary
  localparam int DIV_W      = FLUX_W + 2;       // signed flux divergence
  localparam int MAG_W      = FLUX_W + 1;       // magnitude of the divergence
  localparam int DP_W       = PRES_W + 1;       // signed pressure thickness
  localparam int PROD_W     = SCALE_W + MAG_W;  // scale times divergence
  localparam int FRAC_SHIFT = 4;                // the factor 16 of the divisor
  localparam int NUM_W      = PROD_W - FRAC_SHIFT;
  localparam int QUO_W      = RATE_W;           // quotient bits worked out one per stage
  localparam int REM_W      = PRES_W;           // remainder stays below the divisor

  localparam logic [SCALE_W-1:0] RATE_SCALE_RST = SCALE_W'(55271424);
  localparam logic [RATE_W-1:0]  RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0]  RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  typedef struct packed {
    logic [FLUX_W-1:0] up_flux_lower;
    logic [FLUX_W-1:0] down_flux_lower;
    logic [FLUX_W-1:0] up_flux_upper;
    logic [FLUX_W-1:0] down_flux_upper;
    logic [PRES_W-1:0] pressure_lower;
    logic [PRES_W-1:0] pressure_upper;
  } lhr_layer_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] tendency;
    logic                     zero_thickness;
    logic                     rate_saturated;
  } lhr_result_t;

  // Flags that ride along with an item through the divider.
  typedef struct packed {
    logic neg;   // divergence and thickness differ in sign
    logic zero;  // thickness is zero
    logic big;   // quotient is at least 2^32
  } lhr_side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  bits;     // low dividend bits, shifted out as quotient bits come in
    logic [PRES_W-1:0] divisor;
    lhr_side_t         side;
  } lhr_div_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    lhr_side_t        side;
  } lhr_quo_t;

endpackage

[rtl/lhr_stream_if.sv]
// Valid/ready channel that carries one word of type T per handshake.
// No dependencies; the payload type is given where the channel is instantiated.

interface lhr_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[rtl/lhr_divider.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on lhr_pkg for the stage word and result types.

module lhr_divider import lhr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     dvd_valid,
  input  lhr_div_t dvd,
  output logic     quo_valid,
  output lhr_quo_t quo
);

  lhr_div_t         stg [QUO_W];
  logic [QUO_W-1:0] vld;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  function automatic lhr_div_t div_step(input lhr_div_t w);
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    lhr_div_t       r;
    r     = w;
    trial = {w.rem, w.bits[QUO_W-1]};
    diff  = trial - {1'b0, w.divisor};
    if (trial >= {1'b0, w.divisor}) begin
      r.rem  = diff[REM_W-1:0];
      r.bits = {w.bits[QUO_W-2:0], 1'b1};
    end else begin
      r.rem  = trial[REM_W-1:0];
      r.bits = {w.bits[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-2:0], dvd_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= div_step(dvd);
      for (int i = 1; i < QUO_W; i++) begin
        stg[i] <= div_step(stg[i-1]);
      end
    end
  end

  assign quo_valid = vld[QUO_W-1];
  assign quo.quo   = stg[QUO_W-1].bits;
  assign quo.side  = stg[QUO_W-1].side;

endmodule

[rtl/layer_heating_rate_top.sv]
// Layer heating rate from flux divergence: front stages, divider, clamp, output buffer.
// Depends on lhr_pkg, lhr_stream_if and lhr_divider.
//
//   channel   direction  word           handshake
//   layer     in         lhr_layer_t    valid/ready
//   heating   out        lhr_result_t   valid/ready
//   cfg_wr_*  in         rate_scale     write enable, no ready
//
// One word is accepted per cycle unless stalled; its result passes four front stages
// (net flux, magnitudes, multiply, range check), 32 divider stages and the output buffer.
// The 32-stage restoring divider, one quotient bit per stage, sets the latency.
// Reset clears all valid bits and the output buffer and loads the reset rate scale.
// A stall on heating freezes the pipeline only once the two-word output buffer is full.

module layer_heating_rate_top import lhr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lhr_stream_if.sink         layer,
  lhr_stream_if.source       heating,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data
);

  localparam int OUT_DEPTH = 2;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  logic [SCALE_W-1:0] rate_scale;
  logic               adv;

  // Stage 1: net flux and thickness.
  logic                    v1;
  logic signed [DIV_W-1:0] dflux;
  logic signed [DP_W-1:0]  dp;
  logic signed [NET_W-1:0] net_lower_next;
  logic signed [NET_W-1:0] net_upper_next;
  logic signed [DIV_W-1:0] dflux_next;
  logic signed [DP_W-1:0]  dp_next;

  // Stage 2: magnitudes and signs.
  logic              v2;
  logic [MAG_W-1:0]  mf;
  logic [PRES_W-1:0] mp2;
  lhr_side_t         side2;
  logic [DIV_W-1:0]  mf_full;
  logic [DP_W-1:0]   mp_full;

  // Stage 3: product.
  logic              v3;
  logic [NUM_W-1:0]  num;
  logic [PRES_W-1:0] mp3;
  lhr_side_t         side3;
  logic [PROD_W-1:0] prod;

  // Stage 4: range check and divider load.
  logic             v4;
  lhr_div_t         dvd4;
  logic [REM_W-1:0] num_hi;
  logic             big_next;

  logic        quo_valid;
  lhr_quo_t    quo;
  lhr_result_t res_next;

  lhr_result_t      obuf [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale <= RATE_SCALE_RST;
    end else if (cfg_wr_en) begin
      rate_scale <= cfg_wr_data;
    end
  end

  assign adv         = (count != CNT_W'(OUT_DEPTH)) || heating.ready;
  assign layer.ready = adv;

  always_comb begin
    net_lower_next = $signed({1'b0, layer.data.up_flux_lower})
                   - $signed({1'b0, layer.data.down_flux_lower});
    net_upper_next = $signed({1'b0, layer.data.up_flux_upper})
                   - $signed({1'b0, layer.data.down_flux_upper});
    dflux_next     = DIV_W'(net_lower_next) - DIV_W'(net_upper_next);
    dp_next        = $signed({1'b0, layer.data.pressure_lower})
                   - $signed({1'b0, layer.data.pressure_upper});
  end

  always_comb begin
    mf_full = dflux[DIV_W-1] ? DIV_W'(-dflux) : DIV_W'(dflux);
    mp_full = dp[DP_W-1] ? DP_W'(-dp) : DP_W'(dp);
  end

  assign prod = PROD_W'(rate_scale) * PROD_W'(mf);

  // A quotient of 2^32 or more shows already in the high dividend bits.
  assign num_hi   = num[NUM_W-1:QUO_W];
  assign big_next = (num_hi >= mp3) && !side3.zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= layer.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dflux <= dflux_next;
      dp    <= dp_next;

      mf         <= mf_full[MAG_W-1:0];
      mp2        <= mp_full[PRES_W-1:0];
      side2.neg  <= dflux[DIV_W-1] ^ dp[DP_W-1];
      side2.zero <= (dp == '0);
      side2.big  <= 1'b0;

      num   <= prod[PROD_W-1:FRAC_SHIFT];
      mp3   <= mp2;
      side3 <= side2;

      dvd4.rem       <= big_next ? '0 : num_hi;
      dvd4.bits      <= num[QUO_W-1:0];
      dvd4.divisor   <= mp3;
      dvd4.side.neg  <= side3.neg;
      dvd4.side.zero <= side3.zero;
      dvd4.side.big  <= big_next;
    end
  end

  lhr_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .dvd_valid (v4),
    .dvd       (dvd4),
    .quo_valid (quo_valid),
    .quo       (quo)
  );

  // Sign, clamp and zero-thickness flag. A negative result may reach magnitude 2^31, a positive one only 2^31-1.
  always_comb begin
    res_next.tendency       = '0;
    res_next.zero_thickness = 1'b0;
    res_next.rate_saturated = 1'b0;
    if (quo.side.zero) begin
      res_next.zero_thickness = 1'b1;
    end else if (!quo.side.neg) begin
      if (quo.side.big || quo.quo[QUO_W-1]) begin
        res_next.tendency       = RATE_MAX;
        res_next.rate_saturated = 1'b1;
      end else begin
        res_next.tendency = quo.quo;
      end
    end else begin
      if (quo.side.big || (quo.quo > RATE_MIN)) begin
        res_next.tendency       = RATE_MIN;
        res_next.rate_saturated = 1'b1;
      end else begin
        res_next.tendency = RATE_W'(-quo.quo);
      end
    end
  end

  assign push = adv && quo_valid;
  assign pop  = heating.valid && heating.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= res_next;
    end
  end

  assign heating.valid = (count != '0);
  assign heating.data  = obuf[rd_ptr];

endmodule

[rtl/lhr_checker.sv]
// Port-level checks of the layer heating rate block, bound to its top level.
// Depends on lhr_pkg for the result type and the clamp limits.

module lhr_checker import lhr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        layer_ready,
  input logic        heating_valid,
  input logic        heating_ready,
  input lhr_result_t heating_data
);

  // Reset empties the output buffer.
  a_rst_empty: assert property (@(posedge clk) rst |=> !heating_valid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      heating_valid && !heating_ready |=> heating_valid && $stable(heating_data))
    else $error("stalled result word changed or dropped");

  // With nothing waiting at the output the pipeline can never be stalled.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
      !heating_valid |-> layer_ready)
    else $error("input stalled while the output is empty");

  a_zero: assert property (@(posedge clk) disable iff (rst)
      heating_valid && heating_data.zero_thickness |->
      heating_data.tendency == '0 && !heating_data.rate_saturated)
    else $error("zero thickness with a nonzero rate or saturation");

  a_sat: assert property (@(posedge clk) disable iff (rst)
      heating_valid && heating_data.rate_saturated |->
      heating_data.tendency == RATE_MAX || heating_data.tendency == RATE_MIN)
    else $error("saturated rate is not at a limit");

endmodule

bind layer_heating_rate_top lhr_checker u_lhr_checker (
  .clk           (clk),
  .rst           (rst),
  .layer_ready   (layer.ready),
  .heating_valid (heating.valid),
  .heating_ready (heating.ready),
  .heating_data  (heating.data)
);
